@@ hdl/hpa_pkg.sv @@
`default_nettype none

package hpa_pkg;

  localparam int unsigned HANDLE_W       = 31;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned POOL_SIZE_W    = 7;
  localparam int unsigned POOL_DEPTH_DEF = 64;
  localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_RETURN = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_NOT_IN_USE  = 3'd2,
    ST_LOAD_REJECT = 3'd3,
    ST_NOT_READY   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_IDX,
    S_ALLOC_HND,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    status_e             status;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/hpa_ram.sv @@
`default_nettype none

module hpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/hpa_out_buf.sv @@
`default_nettype none

module hpa_out_buf (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire hpa_pkg::res_t                  res_i,
  output logic                                take_o,
  output logic                                valid_o,
  input  wire logic                           ready_i,
  output logic [hpa_pkg::HANDLE_W-1:0]        handle_o,
  output logic [hpa_pkg::STATUS_W-1:0]        status_o
);

  import hpa_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign take_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i && take_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && take_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o  = valid_q;
  assign handle_o = res_q.handle;
  assign status_o = STATUS_W'(res_q.status);

endmodule

`default_nettype wire

@@ hdl/handle_pool_allocator.sv @@
`default_nettype none
// Flow: load, unused mode, not-ready and empty-pool requests go straight to the
// response state; allocate reads the free stack, then the handle table; return
// scans the handle table memory port one entry per cycle up to the loaded entries.
// Throughput: one item at a time; the next beat is taken once the result moves
// to the output register. Reset clears the loaded and free counters, flags and the
// output valid; pool_size resets to 64; memory contents are not reset.

module handle_pool_allocator #(
  parameter int unsigned POOL_DEPTH = hpa_pkg::POOL_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [hpa_pkg::MODE_W-1:0]        mode_i,
  input  wire logic [hpa_pkg::HANDLE_W-1:0]      handle_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [hpa_pkg::HANDLE_W-1:0]           handle_out_o,
  output logic [hpa_pkg::STATUS_W-1:0]           status_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [hpa_pkg::POOL_SIZE_W-1:0]   cfg_wdata_i
);

  import hpa_pkg::*;

  localparam int unsigned IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned SW = (CW > POOL_SIZE_W) ? CW : POOL_SIZE_W;
  localparam int unsigned TW = HANDLE_W + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(POOL_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  state_e state_q, state_d;
  logic [POOL_SIZE_W-1:0] pool_size_q;
  logic [CW-1:0] loaded_q, loaded_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] free_dec;
  logic failed_q, failed_d;
  logic rd_valid_q, rd_valid_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] rd_idx_q;
  logic [HANDLE_W-1:0] h_q, h_d;
  res_t res_q, res_d;

  logic [SW-1:0] size_ext, eff_s;
  logic [CW-1:0] eff_c;
  logic pool_ready, accept, issuing, match, out_take;

  logic          tbl_we;
  logic [IW-1:0] tbl_waddr, tbl_raddr;
  logic [TW-1:0] tbl_wdata, tbl_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  assign size_ext   = SW'(pool_size_q);
  assign eff_s      = (size_ext > DEPTH_S) ? DEPTH_S : size_ext;
  assign eff_c      = eff_s[CW-1:0];
  assign pool_ready = !failed_q && (loaded_q == eff_c);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign free_dec   = free_q - CW'(1);
  assign issuing    = (cnt_q < loaded_q);
  assign match      = tbl_rdata[HANDLE_W] && (tbl_rdata[HANDLE_W-1:0] == h_q);

  always_comb begin
    state_d    = state_q;
    loaded_d   = loaded_q;
    free_d     = free_q;
    failed_d   = failed_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    h_d        = h_q;
    res_d      = res_q;
    rd_valid_d = 1'b0;
    tbl_we     = 1'b0;
    tbl_waddr  = '0;
    tbl_wdata  = '0;
    tbl_raddr  = '0;
    stk_we     = 1'b0;
    stk_waddr  = free_q[IW-1:0];
    stk_wdata  = '0;
    stk_raddr  = free_dec[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          h_d     = handle_i;
          cnt_d   = '0;
          res_d   = '{handle: '0, status: ST_OK};
          state_d = S_RESP;
          case (mode_e'(mode_i))
            MODE_LOAD: begin
              res_d.status = ST_LOAD_REJECT;
              if (!failed_q) begin
                if ((handle_i == '0) || (loaded_q >= eff_c)) begin
                  failed_d = 1'b1;
                end else begin
                  res_d.status = ST_OK;
                  tbl_we       = 1'b1;
                  tbl_waddr    = loaded_q[IW-1:0];
                  tbl_wdata    = {1'b0, handle_i};
                  if (free_q < DEPTH_C) begin
                    stk_we    = 1'b1;
                    stk_wdata = loaded_q[IW-1:0];
                    free_d    = free_q + CW'(1);
                  end
                  loaded_d = loaded_q + CW'(1);
                end
              end
            end
            MODE_ALLOC: begin
              if (!pool_ready) begin
                res_d.status = ST_NOT_READY;
              end else if (free_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                free_d  = free_dec;
                state_d = S_ALLOC_IDX;
              end
            end
            MODE_RETURN: begin
              if (!pool_ready) begin
                res_d.status = ST_NOT_READY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC_IDX: begin
        tbl_raddr = stk_rdata;
        idx_d     = stk_rdata;
        state_d   = S_ALLOC_HND;
      end
      S_ALLOC_HND: begin
        tbl_we    = 1'b1;
        tbl_waddr = idx_q;
        tbl_wdata = {1'b1, tbl_rdata[HANDLE_W-1:0]};
        res_d     = '{handle: tbl_rdata[HANDLE_W-1:0], status: ST_OK};
        state_d   = S_RESP;
      end
      S_SCAN: begin
        tbl_raddr = cnt_q[IW-1:0];
        if (rd_valid_q && match) begin
          tbl_we    = 1'b1;
          tbl_waddr = rd_idx_q;
          tbl_wdata = {1'b0, h_q};
          if (free_q < DEPTH_C) begin
            stk_we    = 1'b1;
            stk_wdata = rd_idx_q;
            free_d    = free_q + CW'(1);
          end
          res_d.status = ST_OK;
          state_d      = S_RESP;
        end else if (!rd_valid_q && !issuing) begin
          res_d.status = ST_NOT_IN_USE;
          state_d      = S_RESP;
        end else if (issuing) begin
          cnt_d      = cnt_q + CW'(1);
          rd_valid_d = 1'b1;
        end
      end
      S_RESP: begin
        if (out_take) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_size_q <= POOL_SIZE_RST;
      loaded_q    <= '0;
      free_q      <= '0;
      failed_q    <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      loaded_q   <= loaded_d;
      free_q     <= free_d;
      failed_q   <= failed_d;
      rd_valid_q <= rd_valid_d;
      if (cfg_we_i) begin
        pool_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    idx_q    <= idx_d;
    h_q      <= h_d;
    res_q    <= res_d;
    rd_idx_q <= cnt_q[IW-1:0];
  end

  hpa_ram #(
    .WIDTH (TW),
    .DEPTH (POOL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  hpa_ram #(
    .WIDTH (IW),
    .DEPTH (POOL_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  hpa_out_buf u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (state_q == S_RESP),
    .res_i    (res_q),
    .take_o   (out_take),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .handle_o (handle_out_o),
    .status_o (status_o)
  );

endmodule

`default_nettype wire
